FILE: design/eps_pkg.sv
package eps_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEV_PRESENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_BYTES   = 1'd1;

  // Reset values of the registers
  localparam logic        DEV_PRESENT_RST = 1'b1;
  localparam logic [16:0] DEV_BYTES_RST   = 17'h10000;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  // Requested operations
  localparam logic [1:0] OP_ERASE   = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_ILLEGAL = 2'd3;

  // Active operation held in the engine
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ERASE = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Engine phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CMD   = 2'd1;
  localparam logic [1:0] PH_ERASE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PROGRESS  = 3'd1;
  localparam logic [2:0] ST_STATE_ERR = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_BUSY      = 3'd5;
  localparam logic [2:0] ST_DEV_ERR   = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [1:0]  op;
    logic [15:0] address;
    logic [16:0] length;
    logic        dev_busy;
    logic        dev_error;
    logic        dev_write_in_progress;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        finished;
    logic        engine_busy;
    logic        cmd_valid;
    logic        cmd_is_write;
    logic [15:0] cmd_address;
    logic [6:0]  cmd_length;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  op;
    logic [15:0] base;
    logic [16:0] total;
    logic [16:0] done;
  } eng_state_t;

  typedef struct packed {
    logic        present;
    logic [16:0] bytes;
  } dev_cfg_t;

endpackage

FILE: design/eps_rem.sv
// Remainder of a 16-bit address by a constant unit, given a quotient estimate
// that is either exact or one short.
module eps_rem #(
  parameter int UNIT = 64,
  parameter int QW   = 11,
  parameter int RW   = 6
) (
  input  logic [15:0]   address,
  input  logic [QW-1:0] quot,
  output logic [RW-1:0] rem
);

  logic [16:0] prod;
  logic [16:0] diff;
  logic [16:0] fixed;

  assign prod  = 17'(32'(quot) * UNIT);
  assign diff  = {1'b0, address} - prod;
  // one correction step covers the short estimate
  assign fixed = (diff >= 17'(UNIT)) ? diff - 17'(UNIT) : diff;
  assign rem   = RW'(fixed);

endmodule

FILE: design/eps_step.sv
// Next-state and result logic for one start or poll item.
module eps_step #(
  parameter int PAGE_BYTES  = 64,
  parameter int ERASE_BYTES = 64,
  parameter int MEM_BYTES   = 65536,
  parameter int POW         = 6,
  parameter int EOW         = 6
) (
  input  eps_pkg::in_item_t   item,
  input  eps_pkg::dev_cfg_t   cfg,
  input  eps_pkg::eng_state_t st,
  input  logic [POW-1:0]      page_off,
  input  logic [POW-1:0]      page_rem,
  input  logic [EOW-1:0]      erase_rem,
  output eps_pkg::eng_state_t st_nxt,
  output logic [POW-1:0]      page_off_nxt,
  output eps_pkg::out_item_t  res
);
  import eps_pkg::*;

  function automatic logic [16:0] min17(input logic [16:0] a, input logic [16:0] b);
    min17 = (a < b) ? a : b;
  endfunction

  logic        usable;
  logic [16:0] lim;

  // start path
  logic [16:0] s_ch_e;
  logic [16:0] s_ch_p;
  logic [18:0] s_end;
  logic        s_oor;

  // poll path
  logic [16:0] remain;
  logic [16:0] e_done;
  logic [16:0] p_done;
  logic [16:0] n_ch;
  logic [17:0] n_cur;
  logic [18:0] n_end;
  logic        n_oor;

  assign usable = cfg.present && (cfg.bytes != '0);
  assign lim    = (MEM_BYTES > 131071 || 32'(cfg.bytes) < MEM_BYTES) ?
                  cfg.bytes : 17'(MEM_BYTES);

  // first chunk of a fresh request, room up to the next boundary
  assign s_ch_e = min17(item.length, 17'(ERASE_BYTES) - 17'(erase_rem));
  assign s_ch_p = min17(item.length, 17'(PAGE_BYTES) - 17'(page_rem));
  assign s_end  = {3'b0, item.address} + {2'b0, s_ch_p};
  assign s_oor  = s_end > {2'b0, lim};

  // later chunks start on a boundary
  assign remain = st.total - st.done;
  assign e_done = st.done + min17(remain, 17'(ERASE_BYTES));
  assign p_done = st.done + min17(remain, 17'(PAGE_BYTES) - 17'(page_off));
  assign n_ch   = min17(st.total - p_done, 17'(PAGE_BYTES));
  assign n_cur  = {2'b0, st.base} + {1'b0, p_done};
  assign n_end  = {1'b0, n_cur} + {2'b0, n_ch};
  assign n_oor  = n_end > {2'b0, lim};

  always_comb begin
    st_nxt       = st;
    page_off_nxt = page_off;
    res          = '0;
    res.status   = ST_OK;

    if (item.kind == KIND_START) begin
      if (!usable) begin
        res.status = ST_STATE_ERR;
      end else if (item.length == '0 || item.op == OP_ILLEGAL) begin
        res.status = ST_INVALID;
      end else if (st.phase != PH_IDLE) begin
        res.status = ST_BUSY;
      end else begin
        st_nxt.op    = 2'(item.op + 2'd1);
        st_nxt.base  = item.address;
        st_nxt.total = item.length;
        st_nxt.done  = '0;
        if (item.op == OP_ERASE) begin
          // erase retires its first block right away
          st_nxt.done = s_ch_e;
          if (s_ch_e >= item.length) begin
            st_nxt.phase = PH_IDLE;
            st_nxt.op    = ACT_NONE;
            res.finished = 1'b1;
          end else begin
            st_nxt.phase = PH_ERASE;
            res.status   = ST_PROGRESS;
          end
        end else begin
          page_off_nxt = page_rem;
          if (s_oor) begin
            st_nxt.phase = PH_IDLE;
            st_nxt.op    = ACT_NONE;
            res.status   = ST_RANGE;
            res.finished = 1'b1;
          end else begin
            st_nxt.phase     = PH_CMD;
            res.status       = ST_PROGRESS;
            res.cmd_valid    = 1'b1;
            res.cmd_is_write = (item.op == OP_WRITE);
            res.cmd_address  = item.address;
            res.cmd_length   = 7'(s_ch_p);
          end
        end
      end
    end else begin
      if (!usable || st.phase == PH_IDLE) begin
        res.status = (st.phase != PH_IDLE) ? ST_PROGRESS : ST_OK;
      end else if (st.phase == PH_ERASE) begin
        st_nxt.done = e_done;
        if (e_done >= st.total) begin
          st_nxt.phase = PH_IDLE;
          st_nxt.op    = ACT_NONE;
          res.finished = 1'b1;
        end else begin
          res.status = ST_PROGRESS;
        end
      end else if (item.dev_busy) begin
        res.status = ST_PROGRESS;
      end else if (item.dev_error) begin
        st_nxt.phase = PH_IDLE;
        st_nxt.op    = ACT_NONE;
        res.status   = ST_DEV_ERR;
        res.finished = 1'b1;
      end else if (st.op == ACT_WRITE && item.dev_write_in_progress) begin
        res.status = ST_PROGRESS;
      end else begin
        // chunk done: advance to the next page
        st_nxt.done  = p_done;
        page_off_nxt = '0;
        if (p_done >= st.total) begin
          st_nxt.phase = PH_IDLE;
          st_nxt.op    = ACT_NONE;
          res.finished = 1'b1;
        end else if (n_oor) begin
          st_nxt.phase = PH_IDLE;
          st_nxt.op    = ACT_NONE;
          res.status   = ST_RANGE;
          res.finished = 1'b1;
        end else begin
          res.status       = ST_PROGRESS;
          res.cmd_valid    = 1'b1;
          res.cmd_is_write = (st.op == ACT_WRITE);
          res.cmd_address  = 16'(n_cur);
          res.cmd_length   = 7'(n_ch);
        end
      end
    end

    res.engine_busy = (st_nxt.phase != PH_IDLE);
  end

endmodule

FILE: design/eeprom_page_transfer_sequencer.sv
// EEPROM page transfer sequencer.
// Input channel (in_valid/in_stall/in_data) carries start requests and poll
// ticks with device status. Each item gives exactly one result on the output
// channel (out_valid/out_stall/out_data): status, finished, engine_busy and
// an optional chunk command that never crosses a page boundary. Erase issues
// no commands and retires one erase block per item.
// From acceptance to out_valid an item passes one input register, then the
// step logic feeding the result register, which also updates the engine
// state. One item per cycle is sustained while out_stall is low; the rate is
// set by the single step stage, whose state feeds the next item directly.
// The config port (cfg_we/cfg_index/cfg_data) writes device_present and
// device_bytes; write only while no request is in flight.
// Reset (rst_n low, synchronous) empties both stages, idles the engine and
// restores device_present = 1, device_bytes = 65536.
// When out_stall is high with a result waiting, the input register still
// takes one more request; in_stall rises only once both stages are full.
module eeprom_page_transfer_sequencer #(
  parameter int PAGE_BYTES  = 64,
  parameter int ERASE_BYTES = 64,
  parameter int MEM_BYTES   = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  eps_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output eps_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import eps_pkg::*;

  localparam int POW     = $clog2(PAGE_BYTES);
  localparam int EOW     = $clog2(ERASE_BYTES);
  localparam int P_RECIP = 65536 / PAGE_BYTES;
  localparam int E_RECIP = 65536 / ERASE_BYTES;
  localparam int QPW     = $clog2(P_RECIP + 1);
  localparam int QEW     = $clog2(E_RECIP + 1);

  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic [QPW-1:0]   s1_qp_r;
  logic [QEW-1:0]   s1_qe_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  eng_state_t       st_r;
  eng_state_t       st_nxt;
  logic [POW-1:0]   page_off_r;
  logic [POW-1:0]   page_off_nxt;
  dev_cfg_t         cfg_r;
  out_item_t        res;
  logic [POW-1:0]   page_rem;
  logic [EOW-1:0]   erase_rem;
  logic             in_take;
  logic             adv;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // input register, with quotient estimates for the boundary offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
      s1_qp_r   <= QPW'((32'(in_data.address) * P_RECIP) >> 16);
      s1_qe_r   <= QEW'((32'(in_data.address) * E_RECIP) >> 16);
    end
  end

  eps_rem #(.UNIT(PAGE_BYTES), .QW(QPW), .RW(POW)) u_page_rem (
    .address (s1_item_r.address),
    .quot    (s1_qp_r),
    .rem     (page_rem)
  );

  eps_rem #(.UNIT(ERASE_BYTES), .QW(QEW), .RW(EOW)) u_erase_rem (
    .address (s1_item_r.address),
    .quot    (s1_qe_r),
    .rem     (erase_rem)
  );

  eps_step #(
    .PAGE_BYTES  (PAGE_BYTES),
    .ERASE_BYTES (ERASE_BYTES),
    .MEM_BYTES   (MEM_BYTES),
    .POW         (POW),
    .EOW         (EOW)
  ) u_step (
    .item         (s1_item_r),
    .cfg          (cfg_r),
    .st           (st_r),
    .page_off     (page_off_r),
    .page_rem     (page_rem),
    .erase_rem    (erase_rem),
    .st_nxt       (st_nxt),
    .page_off_nxt (page_off_nxt),
    .res          (res)
  );

  // result register and engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      st_r        <= '0;
      page_off_r  <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
        page_off_r  <= page_off_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.present <= DEV_PRESENT_RST;
      cfg_r.bytes   <= DEV_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEV_PRESENT: cfg_r.present <= cfg_data[0];
        REG_DEV_BYTES:   cfg_r.bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  // checks
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.finished |=> st_r.phase == PH_IDLE && st_r.op == ACT_NONE)
    else $error("engine not idle after finishing request");

  a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.finished |-> !out_item_r.engine_busy &&
    !out_item_r.cmd_valid)
    else $error("finished result still shows activity");

  a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.cmd_valid |-> out_item_r.status == ST_PROGRESS &&
    out_item_r.engine_busy)
    else $error("command issued outside an active request");

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.cmd_valid |-> out_item_r.cmd_address == '0 &&
    out_item_r.cmd_length == '0 && !out_item_r.cmd_is_write)
    else $error("command fields not cleared");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && !adv)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/tb_eeprom_page_transfer_sequencer.sv
module tb_eeprom_page_transfer_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import eps_pkg::*;

  localparam int PAGE_BYTES  = 64;
  localparam int ERASE_BYTES = 64;
  localparam int MEM_BYTES   = 65536;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 150;
  localparam int N_PHASES    = 8;

  // Directed script row: either a register write or a request
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor copy of the engine and its registers
  logic [1:0]  m_phase;
  logic [1:0]  m_op;
  int unsigned m_base;
  int unsigned m_total;
  int unsigned m_done;
  bit          m_present;
  int unsigned m_bytes;

  out_item_t   pending_results [$];
  script_row_t script [$];

  int idle_pct;
  int stall_pct;
  int hold_asked;
  int hold_served;
  int hold_left;
  int err_count;
  int n_starts;
  int n_polls;
  int n_checked;
  int n_settings;
  int counted;
  int cycle_count;

  // Random phases: register settings, idling, stalls and request budget
  int phase_present [N_PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1};
  int phase_bytes   [N_PHASES] = '{65536, 4096, 1000, 131071, 65536, 0, 1, 65536};
  int phase_idle    [N_PHASES] = '{0, 47, 0, 13, 47, 13, 0, 13};
  int phase_stall   [N_PHASES] = '{0, 0, 47, 13, 47, 13, 0, 13};
  int phase_items   [N_PHASES] = '{400, 400, 350, 400, 60, 60, 60, 100};

  eeprom_page_transfer_sequencer #(
    .PAGE_BYTES (PAGE_BYTES),
    .ERASE_BYTES(ERASE_BYTES),
    .MEM_BYTES  (MEM_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned size_limit();
    return (m_bytes < MEM_BYTES) ? m_bytes : MEM_BYTES;
  endfunction

  // Bytes left before the next unit boundary, capped by what remains
  function automatic int unsigned span_to_boundary(int unsigned unit);
    int unsigned cur;
    int unsigned remain;
    int unsigned room;
    cur    = m_base + m_done;
    remain = m_total - m_done;
    room   = unit - (cur % unit);
    return (remain < room) ? remain : room;
  endfunction

  // Advance the engine copy by one request and build its result
  function automatic out_item_t step_sequencer(in_item_t it);
    out_item_t   r;
    bit          usable;
    bit          do_issue;
    bit          do_erase;
    bit          do_finish;
    logic [2:0]  fin_status;
    int unsigned cur;
    int unsigned len;
    r          = '0;
    do_issue   = 1'b0;
    do_erase   = 1'b0;
    do_finish  = 1'b0;
    fin_status = ST_OK;
    usable     = m_present && (m_bytes != 0);

    if (it.kind == KIND_START) begin
      if (!usable) begin
        r.status = ST_STATE_ERR;
      end else if (it.length == 0 || it.op == OP_ILLEGAL) begin
        r.status = ST_INVALID;
      end else if (m_phase != PH_IDLE) begin
        r.status = ST_BUSY;
      end else begin
        case (it.op)
          OP_ERASE: m_op = ACT_ERASE;
          OP_WRITE: m_op = ACT_WRITE;
          default:  m_op = ACT_READ;
        endcase
        m_base  = it.address;
        m_total = it.length;
        m_done  = 0;
        if (m_op == ACT_ERASE) do_erase = 1'b1;
        else do_issue = 1'b1;
      end
    end else begin
      if (!usable || m_phase == PH_IDLE) begin
        r.status = (m_phase != PH_IDLE) ? ST_PROGRESS : ST_OK;
      end else if (m_phase == PH_ERASE) begin
        do_erase = 1'b1;
      end else if (it.dev_busy) begin
        r.status = ST_PROGRESS;
      end else if (it.dev_error) begin
        do_finish  = 1'b1;
        fin_status = ST_DEV_ERR;
      end else if (m_op == ACT_WRITE && it.dev_write_in_progress) begin
        r.status = ST_PROGRESS;
      end else begin
        m_done = m_done + span_to_boundary(PAGE_BYTES);
        if (m_done >= m_total) do_finish = 1'b1;
        else do_issue = 1'b1;
      end
    end

    // erase retires one block per request, no command
    if (do_erase) begin
      m_done = m_done + span_to_boundary(ERASE_BYTES);
      if (m_done >= m_total) begin
        do_finish = 1'b1;
      end else begin
        m_phase  = PH_ERASE;
        r.status = ST_PROGRESS;
      end
    end

    // next page chunk, or out of range past the device end
    if (do_issue) begin
      cur = m_base + m_done;
      len = span_to_boundary(PAGE_BYTES);
      if (cur + len > size_limit()) begin
        do_finish  = 1'b1;
        fin_status = ST_RANGE;
      end else begin
        m_phase        = PH_CMD;
        r.status       = ST_PROGRESS;
        r.cmd_valid    = 1'b1;
        r.cmd_is_write = (m_op == ACT_WRITE);
        r.cmd_address  = cur[15:0];
        r.cmd_length   = len[6:0];
      end
    end

    if (do_finish) begin
      m_phase    = PH_IDLE;
      m_op       = ACT_NONE;
      r.status   = fin_status;
      r.finished = 1'b1;
    end
    r.engine_busy = (m_phase != PH_IDLE);
    return r;
  endfunction

  function automatic in_item_t start_req(logic [1:0] op, logic [15:0] addr,
                                         logic [16:0] len, logic [2:0] dev);
    in_item_t it;
    it                       = '0;
    it.kind                  = KIND_START;
    it.op                    = op;
    it.address               = addr;
    it.length                = len;
    it.dev_busy              = dev[2];
    it.dev_error             = dev[1];
    it.dev_write_in_progress = dev[0];
    return it;
  endfunction

  function automatic in_item_t poll_req(bit busy, bit err, bit wip);
    in_item_t it;
    it                       = '0;
    it.kind                  = KIND_POLL;
    it.dev_busy              = busy;
    it.dev_error             = err;
    it.dev_write_in_progress = wip;
    return it;
  endfunction

  function automatic out_item_t res(logic [2:0] st, bit fin, bit busy, bit cv, bit cw,
                                    logic [15:0] ca, logic [6:0] cl);
    out_item_t r;
    r.status       = st;
    r.finished     = fin;
    r.engine_busy  = busy;
    r.cmd_valid    = cv;
    r.cmd_is_write = cw;
    r.cmd_address  = ca;
    r.cmd_length   = cl;
    return r;
  endfunction

  // Random start: mostly legal, sized to the device, a few long or odd ones
  function automatic in_item_t rand_start();
    in_item_t    it;
    int unsigned lim;
    int          pick;
    it  = start_req(chance(90) ? 2'($urandom_range(2)) : OP_ILLEGAL, '0, '0,
                    3'($urandom_range(7)));
    lim = size_limit();
    if (lim > 0 && chance(70)) it.address = 16'($urandom_range(lim - 1));
    else it.address = 16'($urandom);
    if (chance(10)) it.address[5:0] = 6'(63 - $urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 3) it.length = '0;
    else if (pick < 60) it.length = 17'($urandom_range(200, 1));
    else if (pick < 85) it.length = 17'($urandom_range(700, 1));
    else if (pick < 95) it.length = 17'($urandom_range(8, 1));
    else if (pick < 99) it.length = 17'($urandom_range(4096, 1));
    else begin
      // long spans start near the device end and stop at the range check
      it.length = 17'($urandom);
      if (it.op == OP_ERASE) it.op = OP_WRITE;
      if (lim > 256) it.address = 16'(lim - 1 - $urandom_range(255));
    end
    return it;
  endfunction

  // Random poll: status bits random unless a clean one is needed
  function automatic in_item_t rand_poll(bit clean);
    in_item_t it;
    it         = poll_req(!clean && chance(25), !clean && chance(3), !clean && chance(30));
    it.op      = 2'($urandom_range(3));
    it.address = 16'($urandom);
    it.length  = 17'($urandom);
    return it;
  endfunction

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Offer one request, wait for acceptance, queue what it should produce
  task automatic send(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    bit        was_idle;
    while (chance(idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    was_idle  = (m_phase == PH_IDLE);
    predicted = step_sequencer(it);
    pending_results.push_back(typed ? want : predicted);
    if (it.kind == KIND_START) n_starts++;
    else n_polls++;
    if (!(it.kind == KIND_POLL && was_idle)) counted++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_DEV_PRESENT) m_present = val[0];
    else m_bytes = val;
    n_settings++;
    @(posedge clk);
  endtask

  task automatic add_checked(in_item_t it, out_item_t want);
    script.push_back('{1'b0, '0, '0, it, 1'b1, want});
  endtask

  task automatic add_predicted(in_item_t it);
    script.push_back('{1'b0, '0, '0, it, 1'b0, '0});
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    script.push_back('{1'b1, idx, val, '0, 1'b0, '0});
  endtask

  // One start, then polls and rare extra starts until the engine goes idle
  task automatic run_sequence();
    int polls;
    polls = 0;
    if (chance(5)) send(rand_poll(1'b0), 1'b0, '0);
    send(rand_start(), 1'b0, '0);
    while (m_phase != PH_IDLE) begin
      if (chance(4)) begin
        send(rand_start(), 1'b0, '0);
      end else begin
        send(rand_poll(polls > 1500), 1'b0, '0);
        polls++;
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold when the stimulus asks
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served < hold_asked && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= chance(stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        check_field("status", out_data.status, want.status);
        check_field("finished", out_data.finished, want.finished);
        check_field("engine_busy", out_data.engine_busy, want.engine_busy);
        check_field("cmd_valid", out_data.cmd_valid, want.cmd_valid);
        check_field("cmd_is_write", out_data.cmd_is_write, want.cmd_is_write);
        check_field("cmd_address", out_data.cmd_address, want.cmd_address);
        check_field("cmd_length", out_data.cmd_length, want.cmd_length);
        n_checked++;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("eeprom_page_transfer_sequencer verification failed");
        $finish;
      end
    end
  end

  initial begin
    int target;
    m_phase     = PH_IDLE;
    m_op        = ACT_NONE;
    m_base      = 0;
    m_total     = 0;
    m_done      = 0;
    m_present   = DEV_PRESENT_RST;
    m_bytes     = DEV_BYTES_RST;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_asked  = 0;
    hold_served = 0;
    hold_left   = 0;
    err_count   = 0;
    n_starts    = 0;
    n_polls     = 0;
    n_checked   = 0;
    n_settings  = 0;
    counted     = 0;

    // after reset: idle poll, rejects, longest read, device error
    add_checked(poll_req(1, 1, 1), res(ST_OK, 0, 0, 0, 0, 16'h0, 7'd0));
    add_checked(start_req(OP_ILLEGAL, 16'h0, 17'd5, 3'b000),
                res(ST_INVALID, 0, 0, 0, 0, 16'h0, 7'd0));
    add_checked(start_req(OP_ERASE, 16'h0, 17'd0, 3'b000),
                res(ST_INVALID, 0, 0, 0, 0, 16'h0, 7'd0));
    add_checked(start_req(OP_READ, 16'h0, 17'h10000, 3'b000),
                res(ST_PROGRESS, 0, 1, 1, 0, 16'h0, 7'd64));
    add_checked(start_req(OP_WRITE, 16'h10, 17'd4, 3'b000),
                res(ST_BUSY, 0, 1, 0, 0, 16'h0, 7'd0));
    add_checked(start_req(OP_ILLEGAL, 16'h10, 17'd4, 3'b000),
                res(ST_INVALID, 0, 1, 0, 0, 16'h0, 7'd0));
    add_checked(poll_req(1, 0, 0), res(ST_PROGRESS, 0, 1, 0, 0, 16'h0, 7'd0));
    add_checked(poll_req(0, 1, 0), res(ST_DEV_ERR, 1, 0, 0, 0, 16'h0, 7'd0));
    // write at the top address, second chunk runs off the device
    add_checked(start_req(OP_WRITE, 16'hFFFF, 17'd2, 3'b000),
                res(ST_PROGRESS, 0, 1, 1, 1, 16'hFFFF, 7'd1));
    add_checked(poll_req(0, 0, 1), res(ST_PROGRESS, 0, 1, 0, 0, 16'h0, 7'd0));
    add_checked(poll_req(0, 0, 0), res(ST_RANGE, 1, 0, 0, 0, 16'h0, 7'd0));
    // write across a page boundary
    add_predicted(start_req(OP_WRITE, 16'd60, 17'd10, 3'b000));
    add_predicted(poll_req(0, 0, 0));
    add_predicted(poll_req(0, 0, 1));
    add_predicted(poll_req(0, 0, 0));
    // read ignores write-in-progress; busy wins over error
    add_predicted(start_req(OP_READ, 16'd100, 17'd100, 3'b000));
    add_predicted(poll_req(0, 0, 1));
    add_predicted(poll_req(1, 1, 0));
    add_predicted(poll_req(0, 0, 0));
    add_predicted(poll_req(0, 0, 0));
    // erase wrapping past the top address, status bits ignored
    add_predicted(start_req(OP_ERASE, 16'd65530, 17'd20, 3'b111));
    add_predicted(poll_req(1, 1, 1));
    // device removed with a request active: polls ignored, starts refused
    add_predicted(start_req(OP_WRITE, 16'h0, 17'd64, 3'b000));
    add_cfg(REG_DEV_PRESENT, 17'h1FFFE);
    add_checked(poll_req(0, 0, 0), res(ST_PROGRESS, 0, 1, 0, 0, 16'h0, 7'd0));
    add_checked(start_req(OP_READ, 16'h0, 17'd8, 3'b000),
                res(ST_STATE_ERR, 0, 1, 0, 0, 16'h0, 7'd0));
    add_cfg(REG_DEV_PRESENT, 17'd1);
    add_checked(poll_req(0, 0, 0), res(ST_OK, 1, 0, 0, 0, 16'h0, 7'd0));
    // zero size disables the engine
    add_cfg(REG_DEV_BYTES, 17'd0);
    add_checked(start_req(OP_READ, 16'h0, 17'd8, 3'b000),
                res(ST_STATE_ERR, 0, 0, 0, 0, 16'h0, 7'd0));
    add_cfg(REG_DEV_BYTES, 17'h10000);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed script
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_results();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send(script[i].item, script[i].typed, script[i].want);
      end
    end

    // random phases
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_reg(REG_DEV_PRESENT, {16'($urandom), phase_present[p][0]});
      write_reg(REG_DEV_BYTES, 17'(phase_bytes[p]));
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) hold_asked++;
      target = counted + phase_items[p];
      while (counted < target) run_sequence();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d starts and %0d polls under %0d register writes",
             n_starts, n_polls, n_settings);
    $display("%0d results compared, %0d mismatches", n_checked, err_count);
    if (err_count == 0) begin
      $display("eeprom_page_transfer_sequencer verification clean");
    end else begin
      $display("eeprom_page_transfer_sequencer verification failed");
    end
    $finish;
  end

endmodule
